// File: src/assert_macros.svh
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define AST_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_ALWAYS(label, clk, rst_n, expr)
`define AST_IMPLY(label, clk, rst_n, ante, cons)
`endif
`endif

// File: src/fnmg_pkg.sv
package fnmg_pkg;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_gen;

    localparam logic [2:0] REG_HURST_FACTOR = 3'd0;
    localparam logic [2:0] REG_HURST_GAIN   = 3'd1;
    localparam logic [2:0] REG_RANGE_MODE   = 3'd2;
    localparam logic [2:0] REG_QUANT_EN     = 3'd3;
    localparam logic [2:0] REG_QUANT_FACTOR = 3'd4;
    localparam logic [2:0] REG_QUANT_STEP   = 3'd5;
    localparam logic [2:0] REG_SEED         = 3'd6;

    localparam logic [1:0] RANGE_STET    = 2'd0;
    localparam logic [1:0] RANGE_CLIP    = 2'd1;
    localparam logic [1:0] RANGE_WRAP    = 2'd2;
    localparam logic [1:0] RANGE_REFLECT = 2'd3;

    localparam logic [31:0] SEED_RESET = 32'd12345;
    localparam logic [31:0] LCG_MUL    = 32'd69069;

    function automatic t_gen taus_step(t_gen g);
        t_gen n;
        n.a = ((g.a & 32'hFFFF_FFFE) << 12) ^ (((g.a << 13) ^ g.a) >> 19);
        n.b = ((g.b & 32'hFFFF_FFF8) << 4) ^ (((g.b << 2) ^ g.b) >> 25);
        n.c = ((g.c & 32'hFFFF_FFF0) << 17) ^ (((g.c << 3) ^ g.c) >> 11);
        return n;
    endfunction

    function automatic t_gen expand_seed(logic [31:0] seed);
        t_gen        g;
        logic [31:0] w;
        w = seed * LCG_MUL + 32'd1;
        g.a = (w < 32'd2) ? w + 32'd2 : w;
        w = w * LCG_MUL + 32'd1;
        g.b = (w < 32'd8) ? w + 32'd8 : w;
        w = w * LCG_MUL + 32'd1;
        g.c = (w < 32'd16) ? w + 32'd16 : w;
        return g;
    endfunction

    function automatic t_gen reset_words();
        return taus_step(expand_seed(SEED_RESET));
    endfunction

    function automatic longint reset_last(int frac);
        t_gen        g;
        logic [31:0] r;
        longint      v;
        g = reset_words();
        r = g.a ^ g.b ^ g.c;
        v = longint'($signed(r));
        v = v >>> (31 - frac);
        return v / 3;
    endfunction

endpackage

// File: src/fractal_noise_midpoint_generator.sv
// Fractal noise source, one sample per request transaction.
// Input stream: tdata[0] is the request bit; a transaction with request 0
// is taken and produces nothing. Output stream: one signed sample per
// request, held in an output register until the receiver takes it; the
// next request is taken while that sample still waits.
// Config channel: one register write per transaction; the user is to
// write only while the block is idle, which the block does not enforce.
// A seed write re-expands generator words a, b, c and takes no request.
// A request passes through S_RANGE, then S_MUL1 and S_MUL2 with
// quantization on, then S_OUT into the output register; one request is in
// flight at a time. Every BUF_LEN-th request first refills the sample
// memory by midpoint displacement: F_INIT and F_TOP1 to F_TOP3 once, then
// F_LVL per halving level and F_PA, F_PB, F_PC per new point, for the
// two-read one-write memory access per point.
// Reset restores config registers, control state and generator words and
// forces a refill on the first request; the sample memory needs no clearing.
// A stalled receiver holds the sample; at most one more request is taken
// and held until the output register frees.
module fractal_noise_midpoint_generator
    import fnmg_pkg::*;
#(
    parameter int BUF_LEN     = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  logic [7:0]                            i_s_axis_tdata,  // [0] request
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      o_m_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [2:0]                            i_cfg_index,
    input  logic [31:0]                           i_cfg_data
);

    localparam int SB   = SAMPLE_BITS;
    localparam int FRAC = SB - 2;
    localparam int AW   = $clog2(BUF_LEN);
    localparam int DW   = ((SB + 7) / 8) * 8;
    localparam int PW   = SB + 33;
    localparam int KW   = PW - (FRAC + 8);
    localparam int QW   = KW + 1 + 33;
    localparam int NW   = SB + 3;
    localparam logic [AW:0]   POS_END  = (AW + 1)'(BUF_LEN);
    localparam logic [AW-1:0] ADDR_MID = AW'(BUF_LEN / 2);
    localparam logic [AW-1:0] OFF_TOP  = AW'(BUF_LEN / 4);
    localparam logic [AW-1:0] OFF_ONE  = AW'(1);
    localparam logic [32:0]   SCALE_CAP = 33'h1_0000_0000;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RANGE = 4'd1;
    localparam logic [3:0] S_MUL1  = 4'd2;
    localparam logic [3:0] S_MUL2  = 4'd3;
    localparam logic [3:0] S_OUT   = 4'd4;
    localparam logic [3:0] S_ISSUE = 4'd5;
    localparam logic [3:0] F_INIT  = 4'd6;
    localparam logic [3:0] F_TOP1  = 4'd7;
    localparam logic [3:0] F_TOP2  = 4'd8;
    localparam logic [3:0] F_TOP3  = 4'd9;
    localparam logic [3:0] F_LVL   = 4'd10;
    localparam logic [3:0] F_PA    = 4'd11;
    localparam logic [3:0] F_PB    = 4'd12;
    localparam logic [3:0] F_PC    = 4'd13;

    logic [15:0] r_hurst_factor;
    logic [15:0] r_hurst_gain;
    logic [1:0]  r_range_mode;
    logic        r_quant_en;
    logic [31:0] r_quant_factor;
    logic [31:0] r_quant_step;

    logic        r_seed_busy;
    logic [1:0]  r_seed_cnt;
    logic [31:0] r_w;
    t_gen        r_gen;

    logic [3:0]  r_state;
    logic [3:0]  n_state;
    logic [AW:0] r_pos;
    logic [AW-1:0] r_i;
    logic [AW-1:0] r_off;
    logic          r_b_last;
    logic [32:0]   r_scale;
    logic signed [SB-2:0] r_rnd;
    logic signed [NW-1:0] r_nz;
    logic signed [SB-1:0] r_mean;
    logic signed [SB-1:0] r_last;
    logic signed [SB-1:0] r_x;
    logic signed [PW-1:0] r_qprod;
    logic signed [QW-1:0] r_qres;
    logic [SB-1:0] r_out;
    logic          r_ovalid;

    logic [SB-1:0] mem [BUF_LEN];
    logic [SB-1:0] r_rd_a;
    logic [SB-1:0] r_rd_b;
    logic [AW-1:0] w_ra;
    logic [AW-1:0] w_rb;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [SB-1:0] w_wd;

    t_gen        w_gen_next;
    logic [31:0] w_word;
    logic signed [SB-2:0] w_rnd;
    logic        w_draw;
    logic [31:0] w_lcg;
    logic [31:0] w_lcg_min;
    logic [31:0] w_seed_word;

    logic        w_in_acc;
    logic        w_cfg_acc;
    logic        w_out_free;

    logic signed [PW-1:0] w_nprod;
    logic signed [NW-1:0] w_nz;
    logic signed [SB-1:0] w_nz_sat;
    logic signed [SB:0]   w_pair;
    logic signed [NW-1:0] w_sum;
    logic signed [SB-1:0] w_sum_sat;
    logic [48:0]          w_sprod;
    logic [33:0]          w_sshift;
    logic [AW:0]          w_next_i;
    logic [AW:0]          w_hi_addr;

    logic signed [SB+1:0] w_xe;
    logic signed [SB+1:0] w_rng;
    logic [SB:0]          w_t4;
    logic signed [SB+1:0] w_one;
    logic signed [KW-1:0] w_k;
    logic signed [QW-1:0] w_qsh;
    logic signed [SB-1:0] w_qsat;
    logic [SB-1:0]        w_result;

    assign o_cfg_ready     = 1'b1;
    assign w_cfg_acc       = i_cfg_valid && o_cfg_ready;
    assign o_s_axis_tready = (r_state == S_IDLE) && !r_seed_busy;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_ovalid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = DW'(r_out);

    assign w_gen_next = taus_step(r_gen);
    assign w_word     = w_gen_next.a ^ w_gen_next.b ^ w_gen_next.c;
    assign w_rnd      = (SB - 1)'($signed(w_word) >>> (31 - FRAC));
    assign w_draw     = (r_state == F_INIT) || (r_state == F_TOP1) || (r_state == F_PA);

    assign w_lcg = r_w * LCG_MUL + 32'd1;
    always_comb begin
        unique case (r_seed_cnt)
            2'd0:    w_lcg_min = 32'd2;
            2'd1:    w_lcg_min = 32'd8;
            default: w_lcg_min = 32'd16;
        endcase
    end
    assign w_seed_word = (w_lcg < w_lcg_min) ? w_lcg + w_lcg_min : w_lcg;

    assign w_nprod  = PW'(r_rnd * $signed({1'b0, r_scale}));
    assign w_nz     = NW'(w_nprod >>> 30);
    assign w_nz_sat = (&r_nz[NW-1:SB-1] || ~|r_nz[NW-1:SB-1]) ? r_nz[SB-1:0]
                    : (r_nz[NW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});
    assign w_pair   = $signed({r_rd_a[SB-1], r_rd_a})
                    + (r_b_last ? $signed({r_last[SB-1], r_last})
                                : $signed({r_rd_b[SB-1], r_rd_b}));
    assign w_sum    = NW'(r_mean) + r_nz;
    assign w_sum_sat = (&w_sum[NW-1:SB-1] || ~|w_sum[NW-1:SB-1]) ? w_sum[SB-1:0]
                     : (w_sum[NW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});
    assign w_sprod  = r_scale * r_hurst_factor;
    assign w_sshift = w_sprod[48:15];
    assign w_next_i = {1'b0, r_i} + {r_off, 1'b0};
    assign w_hi_addr = {1'b0, r_i} + {1'b0, r_off};

    assign w_ra = (r_state == F_PA) ? (r_i - r_off) : r_pos[AW-1:0];
    assign w_rb = w_hi_addr[AW-1:0];

    always_comb begin
        w_we = 1'b0;
        w_wa = r_i;
        w_wd = w_sum_sat;
        unique case (r_state)
            F_INIT: begin
                w_we = 1'b1;
                w_wa = '0;
                w_wd = r_last;
            end
            F_TOP2: begin
                w_we = 1'b1;
                w_wa = ADDR_MID;
                w_wd = w_nz_sat;
            end
            F_PC: begin
                w_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd_a <= mem[w_ra];
        r_rd_b <= mem[w_rb];
    end

    assign w_one = (SB + 2)'(1) <<< FRAC;
    assign w_xe  = $signed({{2{r_rd_a[SB-1]}}, r_rd_a}) + w_one;
    always_comb begin
        w_t4  = {1'b0, w_xe[SB-1:0]};
        w_rng = $signed({{2{r_rd_a[SB-1]}}, r_rd_a});
        unique case (r_range_mode)
            RANGE_CLIP: begin
                if (w_rng > w_one) begin
                    w_rng = w_one;
                end else if (w_rng < -w_one) begin
                    w_rng = -w_one;
                end
            end
            RANGE_WRAP: begin
                w_rng = $signed({1'b0, w_xe[FRAC:0]}) - w_one;
            end
            RANGE_REFLECT: begin
                if (w_t4 > (SB + 1)'(2) << FRAC) begin
                    w_t4 = ((SB + 1)'(4) << FRAC) - w_t4;
                end
                w_rng = $signed({1'b0, w_t4}) - w_one;
            end
            RANGE_STET: begin
            end
        endcase
    end

    assign w_k    = KW'(r_qprod >>> (FRAC + 8));
    assign w_qsh  = r_qres >>> (32 - FRAC);
    assign w_qsat = (&w_qsh[QW-1:SB-1] || ~|w_qsh[QW-1:SB-1]) ? w_qsh[SB-1:0]
                  : (w_qsh[QW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}});
    assign w_result = r_quant_en ? w_qsat : r_x;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_s_axis_tdata[0]) begin
                    n_state = (r_pos == POS_END) ? F_INIT : S_RANGE;
                end
            end
            S_ISSUE: n_state = S_RANGE;
            S_RANGE: n_state = r_quant_en ? S_MUL1 : S_OUT;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_OUT;
            S_OUT:   n_state = w_out_free ? S_IDLE : S_OUT;
            F_INIT:  n_state = F_TOP1;
            F_TOP1:  n_state = F_TOP2;
            F_TOP2:  n_state = F_TOP3;
            F_TOP3:  n_state = F_LVL;
            F_LVL:   n_state = F_PA;
            F_PA:    n_state = F_PB;
            F_PB:    n_state = F_PC;
            F_PC: begin
                if (w_next_i >= POS_END) begin
                    n_state = (r_off == OFF_ONE) ? S_ISSUE : F_LVL;
                end else begin
                    n_state = F_PA;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hurst_factor <= 16'd32768;
            r_hurst_gain   <= 16'd9459;
            r_range_mode   <= RANGE_STET;
            r_quant_en     <= 1'b0;
            r_quant_factor <= 32'd256;
            r_quant_step   <= 32'h8000_0000;
            r_seed_busy    <= 1'b0;
            r_seed_cnt     <= 2'd0;
            r_gen          <= reset_words();
            r_last         <= SB'(reset_last(FRAC));
            r_state        <= S_IDLE;
            r_pos          <= POS_END;
            r_ovalid       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    REG_HURST_FACTOR: r_hurst_factor <= i_cfg_data[15:0];
                    REG_HURST_GAIN:   r_hurst_gain   <= i_cfg_data[15:0];
                    REG_RANGE_MODE:   r_range_mode   <= i_cfg_data[1:0];
                    REG_QUANT_EN:     r_quant_en     <= i_cfg_data[0];
                    REG_QUANT_FACTOR: r_quant_factor <= i_cfg_data;
                    REG_QUANT_STEP:   r_quant_step   <= i_cfg_data;
                    REG_SEED: begin
                        r_w         <= i_cfg_data;
                        r_seed_busy <= 1'b1;
                        r_seed_cnt  <= 2'd0;
                    end
                    default: begin
                    end
                endcase
            end
            if (r_seed_busy && !(w_cfg_acc && i_cfg_index == REG_SEED)) begin
                r_w <= w_lcg;
                unique case (r_seed_cnt)
                    2'd0:    r_gen.a <= w_seed_word;
                    2'd1:    r_gen.b <= w_seed_word;
                    default: r_gen.c <= w_seed_word;
                endcase
                r_seed_cnt <= r_seed_cnt + 2'd1;
                if (r_seed_cnt == 2'd2) begin
                    r_seed_busy <= 1'b0;
                end
            end else if (w_draw) begin
                r_gen <= w_gen_next;
            end
            if (r_state == F_TOP3) begin
                r_last <= w_nz_sat;
            end
            if ((r_state == S_IDLE && w_in_acc && i_s_axis_tdata[0] && r_pos != POS_END)
                    || r_state == S_ISSUE) begin
                r_pos <= r_pos + 1'b1;
            end else if (r_state == F_PC && n_state == S_ISSUE) begin
                r_pos <= '0;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_rnd <= w_rnd;
        end
        if (r_state == F_TOP1 || r_state == F_TOP2 || r_state == F_PB) begin
            r_nz <= w_nz;
        end
        unique case (r_state)
            F_INIT: r_scale <= {2'b00, r_hurst_gain, 15'd0};
            F_TOP3: r_off   <= OFF_TOP;
            F_LVL: begin
                r_scale <= (w_sshift > {1'b0, SCALE_CAP}) ? SCALE_CAP : w_sshift[32:0];
                r_i     <= r_off;
            end
            F_PA:   r_b_last <= (w_hi_addr == POS_END);
            F_PB:   r_mean <= w_pair[SB:1];
            F_PC: begin
                if (w_next_i >= POS_END) begin
                    r_off <= r_off >> 1;
                end else begin
                    r_i <= w_next_i[AW-1:0];
                end
            end
            S_RANGE: r_x <= w_rng[SB-1:0];
            S_MUL1:  r_qprod <= PW'(r_x * $signed({1'b0, r_quant_factor}));
            S_MUL2:  r_qres <= QW'($signed({w_k, 1'b1}) * $signed({1'b0, r_quant_step}));
            S_OUT: begin
                if (w_out_free) begin
                    r_out <= w_result;
                end
            end
            default: begin
            end
        endcase
    end

    `include "assert_macros.svh"

    `AST_ALWAYS(a_ready_idle, i_clk, i_rst_n, !o_s_axis_tready || (r_state == S_IDLE))
    `AST_ALWAYS(a_pos_bound, i_clk, i_rst_n, r_pos <= POS_END)
    `AST_ALWAYS(a_we_refill, i_clk, i_rst_n, !w_we || (r_state == F_INIT) || (r_state == F_TOP2) || (r_state == F_PC))
    `AST_IMPLY(a_refill_start, i_clk, i_rst_n, w_in_acc && i_s_axis_tdata[0] && (r_pos == POS_END), r_state == F_INIT)

endmodule

// File: bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fnmg_pkg::*;

    localparam int BUF_LEN     = 4096;
    localparam int SAMPLE_BITS = 24;
    localparam int FRAC        = SAMPLE_BITS - 2;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam logic [2:0] REG_UNMAPPED = 3'd7;

    class noise_predictor;
        longint      store[BUF_LEN + 1];
        int unsigned rd_pos;
        t_gen        gen;
        logic [15:0] hurst_factor;
        logic [15:0] hurst_gain;
        logic [1:0]  range_mode;
        logic        quant_en;
        logic [31:0] quant_factor;
        logic [31:0] quant_step;
        logic [31:0] seed;
        logic [SAMPLE_BITS-1:0] pending_samples[$];
        int          errors;

        function new();
            hurst_factor = 16'd32768;
            hurst_gain   = 16'd9459;
            range_mode   = RANGE_STET;
            quant_en     = 1'b0;
            quant_factor = 32'd256;
            quant_step   = 32'h8000_0000;
            seed         = SEED_RESET;
            errors       = 0;
            load_seed();
            foreach (store[i]) store[i] = 0;
            store[BUF_LEN] = next_rand() / 3;
            rd_pos = BUF_LEN;
        endfunction

        function void load_seed();
            logic [31:0] w;
            w = seed * 32'd69069 + 32'd1;
            gen.a = (w < 32'd2) ? w + 32'd2 : w;
            w = w * 32'd69069 + 32'd1;
            gen.b = (w < 32'd8) ? w + 32'd8 : w;
            w = w * 32'd69069 + 32'd1;
            gen.c = (w < 32'd16) ? w + 32'd16 : w;
        endfunction

        function longint next_rand();
            logic [31:0] r;
            gen.a = ((gen.a & 32'hFFFF_FFFE) << 12) ^ (((gen.a << 13) ^ gen.a) >> 19);
            gen.b = ((gen.b & 32'hFFFF_FFF8) << 4) ^ (((gen.b << 2) ^ gen.b) >> 25);
            gen.c = ((gen.c & 32'hFFFF_FFF0) << 17) ^ (((gen.c << 3) ^ gen.c) >> 11);
            r = gen.a ^ gen.b ^ gen.c;
            return longint'($signed(r)) >>> (31 - FRAC);
        endfunction

        function longint clamp_sample(longint v);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
            lo = -hi - 1;
            return v > hi ? hi : (v < lo ? lo : v);
        endfunction

        function longint displacement(longint scale);
            return (next_rand() * scale) >>> 30;
        endfunction

        function void midpoint_refill();
            longint      scale;
            longint      mean;
            int unsigned stride;
            int unsigned off;
            scale  = longint'(hurst_gain) <<< 15;
            stride = BUF_LEN / 2;
            off    = BUF_LEN / 4;
            store[0]       = store[BUF_LEN];
            store[stride]  = clamp_sample(displacement(scale));
            store[BUF_LEN] = clamp_sample(displacement(scale));
            while (off > 0) begin
                scale = (scale * longint'(hurst_factor)) >>> 15;
                if (scale > (longint'(1) <<< 32)) scale = longint'(1) <<< 32;
                for (int unsigned i = off; i < BUF_LEN; i += stride) begin
                    mean = (store[i - off] + store[i + off]) >>> 1;
                    store[i] = clamp_sample(mean + displacement(scale));
                end
                stride = off;
                off    = off / 2;
            end
            rd_pos = 0;
        endfunction

        function longint fold_range(longint x);
            longint one;
            longint t;
            one = longint'(1) <<< FRAC;
            case (range_mode)
                RANGE_CLIP: begin
                    return x > one ? one : (x < -one ? -one : x);
                end
                RANGE_WRAP: begin
                    t = (x + one) % (2 * one);
                    if (t < 0) t += 2 * one;
                    return t - one;
                end
                RANGE_REFLECT: begin
                    t = (x + one) % (4 * one);
                    if (t < 0) t += 4 * one;
                    if (t > 2 * one) t = 4 * one - t;
                    return t - one;
                end
                default: return x;
            endcase
        endfunction

        function longint bit_reduce(longint x);
            longint k;
            longint lim;
            longint step;
            step = longint'(quant_step);
            if (step == 0) return 0;
            k   = (x * longint'(quant_factor)) >>> (FRAC + 8);
            lim = (longint'(1) <<< 33) / step + 2;
            if (k > lim) k = lim;
            if (k < -lim) k = -lim;
            return clamp_sample((2 * k * step + step) >>> (32 - FRAC));
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_HURST_FACTOR: hurst_factor = v[15:0];
                REG_HURST_GAIN:   hurst_gain   = v[15:0];
                REG_RANGE_MODE:   range_mode   = v[1:0];
                REG_QUANT_EN:     quant_en     = v[0];
                REG_QUANT_FACTOR: quant_factor = v;
                REG_QUANT_STEP:   quant_step   = v;
                REG_SEED: begin
                    seed = v;
                    load_seed();
                end
                default: ;
            endcase
        endfunction

        function void take_request(logic req);
            longint x;
            if (!req) return;
            if (rd_pos >= BUF_LEN) midpoint_refill();
            x = store[rd_pos];
            rd_pos++;
            x = fold_range(x);
            if (quant_en) x = bit_reduce(x);
            x = clamp_sample(x);
            pending_samples.push_back(x[SAMPLE_BITS-1:0]);
        endfunction

        task report_mismatch(string what, logic [SAMPLE_BITS-1:0] got,
                             logic [SAMPLE_BITS-1:0] want);
            errors++;
            $display("mismatch %s: got %0d expected %0d at %0t", what,
                     $signed(got), $signed(want), $realtime);
        endtask

        task check_sample(logic [SAMPLE_BITS-1:0] got);
            logic [SAMPLE_BITS-1:0] want;
            if (pending_samples.size() == 0) begin
                report_mismatch("unexpected sample", got, '0);
                return;
            end
            want = pending_samples.pop_front();
            if (got !== want) report_mismatch("sample", got, want);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [23:0] o_m_axis_tdata;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    noise_predictor model;
    bit          quiet;
    int          stall_left;
    longint      cycles;

    fractal_noise_midpoint_generator #(
        .BUF_LEN     (BUF_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("fractal_noise_midpoint_generator regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            model.check_sample(o_m_axis_tdata[SAMPLE_BITS-1:0]);
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(1, 14) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(logic req);
        int gap;
        i_s_axis_tdata  <= {7'd0, req};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        model.take_request(req);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 14);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (model.pending_samples.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        model.write_reg(idx, v);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_burst(int count);
        for (int i = 0; i < count; i++)
            send_request($urandom_range(0, 9) != 0);
    endtask

    task automatic random_settings();
        logic [31:0] v;
        case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 65535;
            2: v = 32768;
            default: v = $urandom_range(0, 65535);
        endcase
        write_reg(REG_HURST_FACTOR, v);
        case ($urandom_range(0, 3))
            0: v = 0;
            1: v = 32768;
            default: v = $urandom_range(0, 32768);
        endcase
        write_reg(REG_HURST_GAIN, v);
        write_reg(REG_RANGE_MODE, $urandom_range(0, 3));
        write_reg(REG_QUANT_EN, $urandom_range(0, 1));
        case ($urandom_range(0, 3))
            0: v = 256;
            1: v = 32'h8000_0000;
            default: v = $urandom_range(256, 32'h8000_0000);
        endcase
        write_reg(REG_QUANT_FACTOR, v);
        case ($urandom_range(0, 3))
            0: v = 256;
            1: v = 32'h8000_0000;
            default: v = $urandom_range(256, 32'h8000_0000);
        endcase
        write_reg(REG_QUANT_STEP, v);
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0: v = 1;
                1: v = 32'hFFFF_FFFF;
                default: v = $urandom();
            endcase
            write_reg(REG_SEED, v);
        end
    endtask

    initial begin
        model           = new();
        quiet           = 1'b0;
        stall_left      = 0;
        cycles          = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(1'b0);
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b0);
        send_request(1'b1);
        drain();
        write_reg(REG_HURST_GAIN, 32'd32768);
        write_reg(REG_HURST_FACTOR, 32'd65535);
        write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
        for (int m = 0; m < 4; m++) begin
            drain();
            write_reg(REG_RANGE_MODE, m);
            send_request(1'b1);
            send_request(1'b1);
        end
        drain();
        write_reg(REG_QUANT_EN, 32'd1);
        write_reg(REG_QUANT_STEP, 32'd0);
        send_request(1'b1);
        send_request(1'b1);
        drain();
        write_reg(REG_QUANT_STEP, 32'h8000_0000);
        write_reg(REG_QUANT_FACTOR, 32'd0);
        send_request(1'b1);
        drain();
        write_reg(REG_QUANT_FACTOR, 32'hFFFF_FFFF);
        write_reg(REG_QUANT_STEP, 32'hFFFF_FFFF);
        write_reg(REG_SEED, 32'hFFFF_FFFF);
        send_request(1'b1);
        send_request(1'b1);
        drain();
        write_reg(REG_QUANT_STEP, 32'd256);
        write_reg(REG_SEED, 32'd0);
        send_request(1'b1);
        send_request(1'b1);

        // mix random settings between bursts
        for (int b = 0; b < 6; b++) begin
            drain();
            random_settings();
            send_burst($urandom_range(200, 280));
        end
        drain();
        quiet = 1'b1;
        random_settings();
        send_burst(300);
        drain();
        repeat (20) @(posedge i_clk);

        if (model.errors == 0 && model.pending_samples.size() == 0) begin
            $display("fractal_noise_midpoint_generator regression: pass");
        end else begin
            $display("fractal_noise_midpoint_generator regression: fail");
        end
        $finish;
    end

endmodule
